// File: hw/rtl/nlrp_pkg.sv
`default_nettype none

package nlrp_pkg;

    // Table and position sizing
    localparam int MAX_EVENTS    = 64;
    localparam int POSITION_BITS = 24;
    localparam int ADDR_W        = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CNT_W         = $clog2(MAX_EVENTS + 1);

    // Field widths
    localparam int CMD_W   = 3;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int SPS_W   = 16;
    localparam int STEPS_W = 7;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Loop length product and its saturation compare
    localparam int MUL_W = SPS_W + STEPS_W;
    localparam int CMP_W = (MUL_W > POSITION_BITS) ? MUL_W : POSITION_BITS;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // Register reset values
    localparam logic [SPS_W-1:0]   SPS_RESET   = SPS_W'(5512);
    localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_CLEAR    = 3'd3,
        CMD_NOTE_ON  = 3'd4,
        CMD_NOTE_OFF = 3'd5
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLES_PER_STEP = 2'd0,
        REG_LOOP_STEPS       = 2'd1,
        REG_PLAY_ENABLE      = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [NOTE_W-1:0] note_number;
        logic [VEL_W-1:0]  note_velocity;
    } t_in_item;

    typedef struct packed {
        logic              is_note_on;
        logic [NOTE_W-1:0] out_note;
        logic [VEL_W-1:0]  out_velocity;
        logic              last_of_run;
    } t_out_item;

    // One stored event
    typedef struct packed {
        logic                     on;
        logic [NOTE_W-1:0]        note;
        logic [VEL_W-1:0]         velocity;
        logic [POSITION_BITS-1:0] position;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// File: hw/rtl/note_loop_recorder_player.sv
`default_nettype none

// Note loop recorder/player. Send one command per transfer on start/i_item
// (taken when start is high and busy is low): tick = one audio sample, start
// record, stop record, clear, note on, note off. While recording, ticks advance
// the record position and notes are stored with that timestamp (up to
// MAX_EVENTS). While playing, a tick emits every stored event whose timestamp
// equals the play position, in table order, one per cycle on o_result with
// o_result_valid high for exactly one cycle; last_of_run marks the final event
// of the tick. The receiver cannot stall: every strobed result must be taken
// that cycle. A playing tick with a nonempty table and nonzero loop holds busy
// while the sequencer scans the table, drains and flushes, one table read per
// cycle through the single RAM read port and the one shared position
// comparator; results trail the scan through the held-match and output
// registers. Every other command completes in the transfer cycle. Configuration
// writes (i_cfg_we) take effect at once and must only be issued while idle.

module note_loop_recorder_player
    import nlrp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // command channel
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_in_item             i_item,
    // result channel
    output logic                      o_result_valid,
    output t_out_item                 o_result,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    // Sequencer: idle, scan table reads, compare last read, flush pending
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_LAST  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [SPS_W-1:0]   r_sps, n_sps;
    logic [STEPS_W-1:0] r_steps, n_steps;
    logic               r_play_en, n_play_en;

    // recorder/player state
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_rec, n_rec;
    logic [POSITION_BITS-1:0] r_rec_pos, n_rec_pos;
    logic [POSITION_BITS-1:0] r_loop_len, n_loop_len;
    logic [POSITION_BITS-1:0] r_play_pos, n_play_pos;

    // scan datapath
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_chk, n_chk;       // RAM read data valid this cycle
    logic              r_pend_vld, n_pend_vld;
    t_entry            r_pend, n_pend;     // held match, waits to learn if last

    // output register
    logic      r_out_vld, n_out_vld;
    t_out_item r_out, n_out;

    // table port
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    t_entry             w_wentry;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry             w_rentry;

    logic                     w_accept;
    logic [MUL_W-1:0]         w_prod;
    logic [POSITION_BITS-1:0] w_len;
    logic                     w_hit;
    logic [POSITION_BITS-1:0] w_pos_inc;

    nlrp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_EVENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    function automatic t_out_item make_result(t_entry e, logic last);
        t_out_item r;
        r.is_note_on   = e.on;
        r.out_note     = e.note;
        r.out_velocity = e.on ? e.velocity : '0;
        r.last_of_run  = last;
        return r;
    endfunction

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_rentry = t_entry'(w_rdata);

    // Default loop length: steps * samples per step, clamped to the position range
    assign w_prod = MUL_W'(r_sps) * MUL_W'(r_steps);
    assign w_len  = (CMP_W'(w_prod) > CMP_W'(POS_MAX)) ? POS_MAX : POSITION_BITS'(w_prod);

    // shared comparator
    assign w_hit = r_chk && (w_rentry.position == r_play_pos);

    // play position advance with wrap at top of range
    assign w_pos_inc = (r_play_pos < POS_MAX) ? (r_play_pos + 1'b1) : '0;

    assign w_waddr            = r_count[ADDR_W-1:0];
    assign w_wentry.on        = (t_cmd'(i_item.command) == CMD_NOTE_ON);
    assign w_wentry.note      = i_item.note_number;
    assign w_wentry.velocity  = w_wentry.on ? i_item.note_velocity : '0;
    assign w_wentry.position  = r_rec_pos;

    always_comb begin
        n_state    = r_state;
        n_sps      = r_sps;
        n_steps    = r_steps;
        n_play_en  = r_play_en;
        n_count    = r_count;
        n_rec      = r_rec;
        n_rec_pos  = r_rec_pos;
        n_loop_len = r_loop_len;
        n_play_pos = r_play_pos;
        n_idx      = r_idx;
        n_chk      = 1'b0;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_out_vld  = 1'b0;
        n_out      = r_out;
        w_we       = 1'b0;

        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_SAMPLES_PER_STEP: n_sps     = i_cfg_data[SPS_W-1:0];
                REG_LOOP_STEPS:       n_steps   = i_cfg_data[STEPS_W-1:0];
                REG_PLAY_ENABLE:      n_play_en = i_cfg_data[0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_cmd'(i_item.command))
                        CMD_START: begin
                            n_rec      = 1'b1;
                            n_count    = '0;
                            n_rec_pos  = '0;
                            n_loop_len = w_len;
                        end
                        CMD_STOP: begin
                            n_rec = 1'b0;
                            if (r_rec_pos != '0) begin
                                n_loop_len = r_rec_pos;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count    = '0;
                            n_rec      = 1'b0;
                            n_play_pos = '0;
                        end
                        CMD_NOTE_ON, CMD_NOTE_OFF: begin
                            if (r_rec && (r_count < CNT_W'(MAX_EVENTS))) begin
                                w_we    = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_TICK: begin
                            if (r_rec) begin
                                if (r_rec_pos < POS_MAX) begin
                                    n_rec_pos = r_rec_pos + 1'b1;
                                end
                            end else if (r_play_en && (r_count != '0) &&
                                         (r_loop_len != '0)) begin
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN, S_DRAIN: begin
                if (w_hit) begin
                    if (r_pend_vld) begin
                        n_out_vld = 1'b1;
                        n_out     = make_result(r_pend, 1'b0);
                    end
                    n_pend     = w_rentry;
                    n_pend_vld = 1'b1;
                end
                if (r_state == S_SCAN) begin
                    n_chk = 1'b1;
                    if (CNT_W'(r_idx) == (r_count - 1'b1)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (r_pend_vld) begin
                    n_out_vld = 1'b1;
                    n_out     = make_result(r_pend, 1'b1);
                end
                n_pend_vld = 1'b0;
                n_play_pos = (w_pos_inc >= r_loop_len) ? '0 : w_pos_inc;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sps      <= SPS_RESET;
            r_steps    <= STEPS_RESET;
            r_play_en  <= 1'b0;
            r_count    <= '0;
            r_rec      <= 1'b0;
            r_rec_pos  <= '0;
            r_loop_len <= '0;
            r_play_pos <= '0;
            r_idx      <= '0;
            r_chk      <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sps      <= n_sps;
            r_steps    <= n_steps;
            r_play_en  <= n_play_en;
            r_count    <= n_count;
            r_rec      <= n_rec;
            r_rec_pos  <= n_rec_pos;
            r_loop_len <= n_loop_len;
            r_play_pos <= n_play_pos;
            r_idx      <= n_idx;
            r_chk      <= n_chk;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

    // held match must be flushed before the sequencer goes idle
    a_pend_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_vld)
        else $error("pending match left over at idle");

    // read data only checked while the scan is running
    a_chk_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk |-> ((r_state == S_SCAN) || (r_state == S_DRAIN)))
        else $error("table read data outside scan");

    // nothing follows the last result of a run in the next cycle
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.last_of_run) |=> !r_out_vld)
        else $error("result directly after last_of_run");

    // table fill never passes its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_EVENTS))
        else $error("event count overflow");

    // results only come out of a scan
    a_out_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ($past(r_state) != S_IDLE))
        else $error("result without scan");

endmodule

`default_nettype wire

// File: hw/rtl/nlrp_ram.sv
`default_nettype none

module nlrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: tb/sv/tb_note_loop_recorder_player.sv
`timescale 1ns / 1ps

module tb_note_loop_recorder_player;
    import nlrp_pkg::*;

    // Commands to send before the run winds down
    localparam int NUM_ITEMS    = 280;
    // Longest table scan plus the drain and the result trail
    localparam int DRAIN_CYCLES = MAX_EVENTS + 4;
    // Cycles with no transfer on either side before the run is abandoned
    localparam int STALL_LIMIT  = 4000;

    // Command codes the block does not define; it must swallow them
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    t_in_item             cmd_bus    = '0;
    logic                 o_result_valid;
    t_out_item            o_result;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    note_loop_recorder_player uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (cmd_bus),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the recorder state and registers,
    // turns every accepted command into the replayed events it must cause,
    // and checks strobed results against them in order.
    // ------------------------------------------------------------------
    class loop_scoreboard;
        t_entry                   stored [MAX_EVENTS];
        int unsigned              num_stored;
        bit                       recording;
        logic [POSITION_BITS-1:0] rec_pos;
        logic [POSITION_BITS-1:0] loop_len;
        logic [POSITION_BITS-1:0] play_pos;
        logic [SPS_W-1:0]         sps;
        logic [STEPS_W-1:0]       steps;
        bit                       play_en;
        t_out_item                expected_replays [$];
        int unsigned              errors;
        int unsigned              effective;
        int unsigned              dropped;
        int unsigned              matched;

        function new();
            num_stored = 0;
            recording  = 1'b0;
            rec_pos    = '0;
            loop_len   = '0;
            play_pos   = '0;
            sps        = SPS_RESET;
            steps      = STEPS_RESET;
            play_en    = 1'b0;
            errors     = 0;
            effective  = 0;
            dropped    = 0;
            matched    = 0;
        endfunction

        function void report_mismatch(string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endfunction

        function int unsigned pending();
            return expected_replays.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_SAMPLES_PER_STEP: sps     = value[SPS_W-1:0];
                REG_LOOP_STEPS:       steps   = value[STEPS_W-1:0];
                REG_PLAY_ENABLE:      play_en = value[0];
                default: ;
            endcase
        endfunction

        // Advance the state by one command; queue the events a tick replays.
        function void predict_replay(t_in_item item);
            logic [31:0] product;
            int unsigned i;
            int unsigned last_idx;
            bit          any_hit;
            t_out_item   ev;
            case (item.command)
                CMD_START: begin
                    product   = 32'(sps) * 32'(steps);
                    loop_len  = (product > 32'(POS_MAX)) ? POS_MAX
                                                         : product[POSITION_BITS-1:0];
                    recording = 1'b1;
                    num_stored = 0;
                    rec_pos   = '0;
                    effective++;
                end
                CMD_STOP: begin
                    recording = 1'b0;
                    if (rec_pos != '0) loop_len = rec_pos;
                    effective++;
                end
                CMD_CLEAR: begin
                    num_stored = 0;
                    recording  = 1'b0;
                    play_pos   = '0;
                    effective++;
                end
                CMD_NOTE_ON, CMD_NOTE_OFF: begin
                    if (recording && num_stored < MAX_EVENTS) begin
                        stored[num_stored].on       = (item.command == CMD_NOTE_ON);
                        stored[num_stored].note     = item.note_number;
                        stored[num_stored].velocity =
                            stored[num_stored].on ? item.note_velocity : '0;
                        stored[num_stored].position = rec_pos;
                        num_stored++;
                        effective++;
                    end else if (recording) begin
                        dropped++;
                    end
                end
                CMD_TICK: begin
                    if (recording) begin
                        if (rec_pos != POS_MAX) rec_pos++;
                        effective++;
                    end else if (play_en && num_stored != 0 && loop_len != '0) begin
                        effective++;
                        any_hit  = 1'b0;
                        last_idx = 0;
                        for (i = 0; i < num_stored; i++) begin
                            if (stored[i].position == play_pos) begin
                                any_hit  = 1'b1;
                                last_idx = i;
                            end
                        end
                        if (any_hit) begin
                            for (i = 0; i <= last_idx; i++) begin
                                if (stored[i].position == play_pos) begin
                                    ev.is_note_on   = stored[i].on;
                                    ev.out_note     = stored[i].note;
                                    ev.out_velocity = stored[i].on ? stored[i].velocity : '0;
                                    ev.last_of_run  = (i == last_idx);
                                    expected_replays = {expected_replays, ev};
                                end
                            end
                        end
                        if (play_pos != POS_MAX) play_pos++;
                        else play_pos = '0;
                        if (play_pos >= loop_len) play_pos = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_replay(t_out_item got);
            t_out_item want;
            if (expected_replays.size() == 0) begin
                report_mismatch($sformatf("unexpected event on=%b note=%0d vel=%0d last=%b",
                    got.is_note_on, got.out_note, got.out_velocity, got.last_of_run));
                return;
            end
            want = expected_replays.pop_front();
            matched++;
            if (got.is_note_on !== want.is_note_on)
                report_mismatch($sformatf("event %0d is_note_on got %b want %b",
                    matched, got.is_note_on, want.is_note_on));
            if (got.out_note !== want.out_note)
                report_mismatch($sformatf("event %0d out_note got %0d want %0d",
                    matched, got.out_note, want.out_note));
            if (got.out_velocity !== want.out_velocity)
                report_mismatch($sformatf("event %0d out_velocity got %0d want %0d",
                    matched, got.out_velocity, want.out_velocity));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("event %0d last_of_run got %b want %b",
                    matched, got.last_of_run, want.last_of_run));
        endfunction
    endclass

    loop_scoreboard sb = new();

    int unsigned accepted_cmds = 0;
    int unsigned stall_cycles  = 0;
    bit          no_gaps       = 1'b0;

    // Monitor: a command transfer is start high with busy low at the edge;
    // results carry no back-pressure, so every strobe is a transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.predict_replay(cmd_bus);
                accepted_cmds++;
            end
            if (o_result_valid) sb.check_replay(o_result);
        end
    end

    // Watchdog: any transfer on either side restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("[%0t] watchdog: %0d cycles without a transfer", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [NOTE_W-1:0] rand_note();
        return NOTE_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [VEL_W-1:0] rand_vel();
        return VEL_W'($urandom_range(0, 127));
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Present one command, hold it until the transfer, then maybe go idle.
    // With no gap start stays high, so the next command follows directly.
    task automatic issue(input logic [CMD_W-1:0] code, input logic [NOTE_W-1:0] note,
                         input logic [VEL_W-1:0] vel);
        t_in_item    item;
        int unsigned gap;
        item.command       = code;
        item.note_number   = note;
        item.note_velocity = vel;
        start   <= 1'b1;
        cmd_bus <= item;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        gap = pick_gap();
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off until every predicted event has been seen and the scan is
    // over; ticks that match nothing still scan, hence the extra pause.
    task automatic wait_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers on consecutive edges; only while idle
    task automatic configure(input logic [CFG_W-1:0] sps_val,
                             input logic [CFG_W-1:0] steps_val,
                             input logic [CFG_W-1:0] play_val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SAMPLES_PER_STEP;
        i_cfg_data <= sps_val;
        @(posedge i_clk);
        sb.set_register(REG_SAMPLES_PER_STEP, sps_val);
        i_cfg_idx  <= REG_LOOP_STEPS;
        i_cfg_data <= steps_val;
        @(posedge i_clk);
        sb.set_register(REG_LOOP_STEPS, steps_val);
        i_cfg_idx  <= REG_PLAY_ENABLE;
        i_cfg_data <= play_val;
        @(posedge i_clk);
        sb.set_register(REG_PLAY_ENABLE, play_val);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic issue_noise();
        if ($urandom_range(0, 2) == 0)
            issue(($urandom_range(0, 1) != 0) ? CMD_NOTE_ON : CMD_NOTE_OFF,
                  rand_note(), rand_vel());
        else
            issue(($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7,
                  rand_note(), rand_vel());
    endtask

    // One record-then-play sequence with random content. fill_table pushes
    // about as many notes as the table holds or more, with few ticks between,
    // so a single tick can replay many table entries.
    task automatic run_phase(input bit fill_table);
        logic [CFG_W-1:0] sps_val;
        logic [CFG_W-1:0] steps_val;
        logic [CFG_W-1:0] play_val;
        logic [STEPS_W-1:0] steps_field;
        int unsigned rec_items;
        int unsigned play_items;
        int unsigned tick_pct;
        int unsigned r;
        int unsigned k;

        wait_until_drained();

        case ($urandom_range(0, 9))
            0:       sps_val = '0;
            1:       sps_val = '1;
            default: sps_val = CFG_W'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 9))
            0:       steps_field = '0;
            1:       steps_field = '1;
            2:       steps_field = STEPS_W'(64);
            default: steps_field = STEPS_W'($urandom_range(1, 4));
        endcase
        // junk above the register width must be ignored
        steps_val = CFG_W'(steps_field) | (CFG_W'($urandom_range(0, 511)) << STEPS_W);
        play_val  = (CFG_W'($urandom_range(0, 32767)) << 1)
                  | CFG_W'($urandom_range(0, 9) < 8);
        configure(sps_val, steps_val, play_val);

        no_gaps = ($urandom_range(0, 3) == 0);

        // skipping the clear keeps the old play position across the restart
        if ($urandom_range(0, 1) == 0) issue(CMD_CLEAR, rand_note(), rand_vel());
        issue(CMD_START, rand_note(), rand_vel());

        rec_items = fill_table ? $urandom_range(66, 80) : $urandom_range(0, 14);
        tick_pct  = fill_table ? 3 : $urandom_range(0, 60);
        for (k = 0; k < rec_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < tick_pct)
                issue(CMD_TICK, rand_note(), rand_vel());
            else if (r < 95)
                issue(($urandom_range(0, 1) != 0) ? CMD_NOTE_ON : CMD_NOTE_OFF,
                      rand_note(), rand_vel());
            else
                issue_noise();
        end
        if ($urandom_range(0, 9) != 0) issue(CMD_STOP, rand_note(), rand_vel());

        play_items = $urandom_range(4, 24);
        for (k = 0; k < play_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 88)      issue(CMD_TICK, rand_note(), rand_vel());
            else if (r < 95) issue_noise();
            else if (r < 97) issue(CMD_CLEAR, rand_note(), rand_vel());
            else             issue(CMD_START, rand_note(), rand_vel());
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: short loop of 4 x 2 samples, playback on
        configure(CFG_W'(4), CFG_W'(2), CFG_W'(1));
        issue(CMD_TICK, '0, '0);                  // empty table, no output
        issue(CMD_SPARE_6, '1, '1);               // undefined code
        issue(CMD_START, '0, '0);
        issue(CMD_NOTE_ON, '1, '1);               // full-scale note and velocity
        issue(CMD_NOTE_OFF, '0, '1);              // off replays with velocity 0
        issue(CMD_NOTE_ON, NOTE_W'(5), '0);       // on with zero velocity stays an on
        issue(CMD_TICK, '0, '0);
        issue(CMD_NOTE_ON, NOTE_W'(60), VEL_W'(64));
        issue(CMD_TICK, '0, '0);
        issue(CMD_TICK, '0, '0);
        issue(CMD_STOP, '0, '0);                  // loop becomes the recorded 3
        repeat (4) issue(CMD_TICK, '0, '0);       // three events, one, none, wrap
        issue(CMD_CLEAR, '0, '0);
        issue(CMD_TICK, '0, '0);                  // cleared table plays nothing

        // Zero samples per step: loop length 0 and an empty stop keeps it
        wait_until_drained();
        configure('0, CFG_W'(2), CFG_W'(1));
        issue(CMD_START, '0, '0);
        issue(CMD_NOTE_ON, rand_note(), rand_vel());
        issue(CMD_STOP, '0, '0);
        issue(CMD_TICK, '0, '0);

        // Largest register values, playback off: ticks after stop are idle
        wait_until_drained();
        configure('1, '1, '0);
        issue(CMD_START, '0, '0);
        issue(CMD_TICK, '0, '0);
        issue(CMD_STOP, '0, '0);
        issue(CMD_TICK, '0, '0);

        // Random: one table overflow up front, then mixed phases
        run_phase(1'b1);
        while (accepted_cmds < NUM_ITEMS) run_phase($urandom_range(0, 7) == 0);

        wait_until_drained();
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d events never replayed", sb.pending()));

        $display("Run: %0d commands taken, %0d of them changed state or replayed",
                 accepted_cmds, sb.effective);
        $display("Run: %0d replayed events checked, %0d notes dropped on a full table",
                 sb.matched, sb.dropped);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
